[src/kmc_pkg.sv]
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types and constants for the 2-D k-means clustering block.
// ----------------------------------------------------------------------------
package kmc_pkg;

  localparam int MAX_POINTS_DEF   = 1024;
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int COORD_W          = 16;
  localparam int IDX_W            = 10;
  localparam int CLU_W            = 4;
  localparam int ITER_W           = 10;
  localparam int CFG_W            = 11;
  localparam int REGIDX_W         = 2;
  localparam int CC_W             = 5;
  localparam int PC_W             = 11;
  localparam int MI_W             = 10;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_SEED  = 2'd1,
    ACT_START = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  localparam logic [REGIDX_W-1:0] REG_CLUSTERS = 2'd0;
  localparam logic [REGIDX_W-1:0] REG_POINTS   = 2'd1;
  localparam logic [REGIDX_W-1:0] REG_ITERS    = 2'd2;

  localparam logic KIND_CENTROID = 1'b0;
  localparam logic KIND_LABEL    = 1'b1;

  typedef struct packed {
    logic pt_wr;
    logic rd;
    logic lbl_clr;
    logic lbl_seed;
    logic lbl_wb;
    logic seed_wr;
    logic issue;
    logic acc_clr;
    logic acc_wb;
    logic div_start;
    logic cen_wb;
    logic out_load;
    logic out_kind;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic div_done;
    logic changed;
    logic moved;
    logic out_free;
  } status_t;

endpackage

[src/kmc_if.sv]
// ----------------------------------------------------------------------------
// kmc_in_if / kmc_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface kmc_in_if import kmc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic [IDX_W-1:0]          point_index;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic [CLU_W-1:0]          seed_cluster;

  modport source (output valid, action, point_index, coord_x, coord_y, seed_cluster,
                  input ready);
  modport sink (input valid, action, point_index, coord_x, coord_y, seed_cluster,
                output ready);
endinterface

interface kmc_out_if import kmc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [CLU_W-1:0]          cluster_id;
  logic                      label_valid;
  logic signed [COORD_W-1:0] centroid_x;
  logic signed [COORD_W-1:0] centroid_y;
  logic [ITER_W-1:0]         iterations_used;
  logic                      converged;
  logic                      last;

  modport source (output valid, kind, cluster_id, label_valid, centroid_x, centroid_y,
                  iterations_used, converged, last, input ready);
  modport sink (input valid, kind, cluster_id, label_valid, centroid_x, centroid_y,
                iterations_used, converged, last, output ready);
endinterface

[src/kmc_div.sv]
// ----------------------------------------------------------------------------
// kmc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kmc_div import kmc_pkg::*; #(
  parameter int DIVIDEND_W = 26,
  parameter int DIVISOR_W  = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0] rem;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  assign shifted = {rem, quotient[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign ge      = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(DIVIDEND_W);
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quotient <= {quotient[DIVIDEND_W-2:0], ge};
        cnt      <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/kmc_ctrl.sv]
// ----------------------------------------------------------------------------
// kmc_ctrl
// Sequencer: config registers, request decode, Lloyd iteration control.
// ----------------------------------------------------------------------------
module kmc_ctrl import kmc_pkg::*; #(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [REGIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [1:0]            action,
  input  logic [IDX_W-1:0]      point_index,
  input  logic [CLU_W-1:0]      seed_cluster,
  input  status_t               st,
  output cmd_t                  cmd,
  output logic [(MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1)-1:0]     addr,
  output logic [(MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1)-1:0] clu,
  output logic [ITER_W-1:0]     iter_count,
  output logic                  conv
);

  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int NW = PW + 1;
  localparam int KW = CW + 1;

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_SEED   = 13'b0000000000100,
    S_QUERY  = 13'b0000000001000,
    S_INIT   = 13'b0000000010000,
    S_RD     = 13'b0000000100000,
    S_RUN    = 13'b0000001000000,
    S_DRAIN  = 13'b0000010000000,
    S_WB     = 13'b0000100000000,
    S_UPD    = 13'b0001000000000,
    S_DIV    = 13'b0010000000000,
    S_END    = 13'b0100000000000,
    S_REPORT = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  logic [CC_W-1:0]   cluster_count;
  logic [PC_W-1:0]   point_count;
  logic [MI_W-1:0]   max_iterations;
  logic [PW-1:0]     pcnt;
  logic [CW-1:0]     ccnt;
  logic [ITER_W-1:0] run_iter;

  logic [KW-1:0]     k_eff;
  logic [NW-1:0]     n_eff;
  logic [MI_W-1:0]   lim;
  logic [ITER_W-1:0] it_next;
  logic              c_last, p_last, idx_ok, seed_ok, accept, done, stop;

  assign k_eff = (cluster_count == '0) ? KW'(1) :
                 ($unsigned(cluster_count) > MAX_CLUSTERS) ? KW'(MAX_CLUSTERS) :
                 KW'(cluster_count);
  assign n_eff = ($unsigned(point_count) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(point_count);
  assign lim   = (max_iterations == '0) ? MI_W'(1) : max_iterations;

  assign c_last  = KW'(ccnt) == k_eff - KW'(1);
  assign p_last  = NW'(pcnt) == n_eff - NW'(1);
  assign idx_ok  = $unsigned(point_index) < MAX_POINTS;
  assign seed_ok = $unsigned(seed_cluster) < MAX_CLUSTERS;
  assign it_next = run_iter + ITER_W'(1);
  assign done    = !st.changed && !st.moved;
  assign stop    = done || (it_next >= lim);

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign addr      = (state == S_IDLE) ? PW'(point_index) : pcnt;
  assign clu       = ccnt;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.lbl_clr = 1'b1;
        if (pcnt == PW'(MAX_POINTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          case (action_t'(action))
            ACT_LOAD: cmd.pt_wr = idx_ok;
            ACT_SEED: begin
              if (idx_ok && seed_ok) begin
                cmd.rd     = 1'b1;
                state_next = S_SEED;
              end
            end
            ACT_START: state_next = S_INIT;
            ACT_QUERY: begin
              if (idx_ok) begin
                cmd.rd     = 1'b1;
                state_next = S_QUERY;
              end
            end
            default: ;
          endcase
        end
      end
      S_SEED: begin
        cmd.seed_wr  = 1'b1;
        cmd.lbl_seed = 1'b1;
        state_next   = S_IDLE;
      end
      S_QUERY: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_LABEL;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_INIT: begin
        cmd.acc_clr = 1'b1;
        state_next  = (n_eff == '0) ? S_UPD : S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_RUN;
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (c_last) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_WB;
      S_WB: begin
        cmd.acc_wb = 1'b1;
        cmd.lbl_wb = 1'b1;
        state_next = p_last ? S_UPD : S_RD;
      end
      S_UPD: begin
        if (st.cnt_zero) begin
          if (c_last) state_next = S_END;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          cmd.cen_wb = 1'b1;
          state_next = c_last ? S_END : S_UPD;
        end
      end
      S_END: state_next = stop ? S_REPORT : S_INIT;
      S_REPORT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_CENTROID;
          cmd.out_last = c_last;
          if (c_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      pcnt           <= '0;
      ccnt           <= '0;
      run_iter       <= '0;
      iter_count     <= '0;
      conv           <= 1'b0;
      cluster_count  <= CC_W'(4);
      point_count    <= PC_W'(1024);
      max_iterations <= MI_W'(100);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_CLUSTERS: cluster_count  <= cfg_data[CC_W-1:0];
          REG_POINTS:   point_count    <= cfg_data[PC_W-1:0];
          REG_ITERS:    max_iterations <= cfg_data[MI_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: pcnt <= pcnt + PW'(1);
        S_IDLE: begin
          if (accept) begin
            pcnt     <= PW'(point_index);
            ccnt     <= CW'(seed_cluster);
            run_iter <= '0;
          end
        end
        S_INIT: begin
          pcnt <= '0;
          ccnt <= '0;
        end
        S_RUN: ccnt <= c_last ? '0 : ccnt + CW'(1);
        S_WB:  pcnt <= pcnt + PW'(1);
        S_UPD: if (st.cnt_zero && !c_last) ccnt <= ccnt + CW'(1);
        S_DIV: if (st.div_done && !c_last) ccnt <= ccnt + CW'(1);
        S_END: begin
          run_iter <= it_next;
          if (stop) begin
            iter_count <= it_next;
            conv       <= done;
            ccnt       <= '0;
          end
        end
        S_REPORT: if (st.out_free && !c_last) ccnt <= ccnt + CW'(1);
        default: ;
      endcase
    end
  end

endmodule

[src/kmc_dp.sv]
// ----------------------------------------------------------------------------
// kmc_dp
// Datapath: point and label stores, centroids, distance pipe, accumulators,
// mean dividers and the result register.
// ----------------------------------------------------------------------------
module kmc_dp import kmc_pkg::*; #(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  input  logic [(MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1)-1:0]     addr,
  input  logic [(MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1)-1:0] clu,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic [ITER_W-1:0]         iter_count,
  input  logic                      conv,
  output status_t                   st,
  kmc_out_if.source                 rsp
);

  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int SW = COORD_W + PW;
  localparam int NW = PW + 1;
  localparam int QW = 2 * COORD_W;
  localparam int DW = QW + 1;

  logic signed [COORD_W-1:0] px_mem [MAX_POINTS];
  logic signed [COORD_W-1:0] py_mem [MAX_POINTS];
  logic [CW:0]               lbl_mem [MAX_POINTS];
  logic signed [COORD_W-1:0] rd_x, rd_y;
  logic [CW:0]               rd_lbl;

  logic signed [COORD_W-1:0] cen_x [MAX_CLUSTERS];
  logic signed [COORD_W-1:0] cen_y [MAX_CLUSTERS];
  logic signed [SW-1:0]      sum_x [MAX_CLUSTERS];
  logic signed [SW-1:0]      sum_y [MAX_CLUSTERS];
  logic [NW-1:0]             cnt   [MAX_CLUSTERS];

  logic signed [COORD_W:0]   dx, dy;
  logic [QW-1:0]             px2, py2;
  logic [QW-1:0]             dxx, dyy;
  logic                      sq_v;
  logic [CW-1:0]             sq_c;
  logic [DW-1:0]             sq_dist, best_d;
  logic [CW-1:0]             best_c;
  logic                      changed, moved;

  logic [SW-1:0]             mag_x, mag_y, q_x, q_y;
  logic [COORD_W-1:0]        qx_lo, qy_lo;
  logic signed [COORD_W-1:0] new_x, new_y;
  logic                      done_x, done_y;

  // point stores, no reset
  always_ff @(posedge clk) begin
    if (cmd.pt_wr) begin
      px_mem[addr] <= coord_x;
      py_mem[addr] <= coord_y;
    end
    if (cmd.rd) begin
      rd_x <= px_mem[addr];
      rd_y <= py_mem[addr];
    end
  end

  // label store: top bit marks an assigned point
  always_ff @(posedge clk) begin
    if (cmd.lbl_clr)       lbl_mem[addr] <= '0;
    else if (cmd.lbl_seed) lbl_mem[addr] <= {1'b1, clu};
    else if (cmd.lbl_wb)   lbl_mem[addr] <= {1'b1, best_c};
    if (cmd.rd) rd_lbl <= lbl_mem[addr];
  end

  // squared distance: one multiply stage, then sum and compare
  assign dx  = (COORD_W+1)'(cen_x[clu]) - (COORD_W+1)'(rd_x);
  assign dy  = (COORD_W+1)'(cen_y[clu]) - (COORD_W+1)'(rd_y);
  // a square of a 17-bit difference fits in 32 bits
  assign px2 = dx * dx;
  assign py2 = dy * dy;
  assign sq_dist = DW'(dxx) + DW'(dyy);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= 1'b0;
    end else begin
      sq_v <= cmd.issue;
    end
    dxx  <= px2;
    dyy  <= py2;
    sq_c <= clu;
    if (sq_v && (sq_c == '0 || sq_dist < best_d)) begin
      best_d <= sq_dist;
      best_c <= sq_c;
    end
  end

  // means, truncated toward zero
  assign mag_x = sum_x[clu][SW-1] ? SW'(-sum_x[clu]) : SW'(sum_x[clu]);
  assign mag_y = sum_y[clu][SW-1] ? SW'(-sum_y[clu]) : SW'(sum_y[clu]);
  assign qx_lo = q_x[COORD_W-1:0];
  assign qy_lo = q_y[COORD_W-1:0];
  assign new_x = sum_x[clu][SW-1] ? COORD_W'(-qx_lo) : COORD_W'(qx_lo);
  assign new_y = sum_y[clu][SW-1] ? COORD_W'(-qy_lo) : COORD_W'(qy_lo);

  kmc_div #(.DIVIDEND_W(SW), .DIVISOR_W(NW)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag_x),
    .divisor  (cnt[clu]),
    .done     (done_x),
    .quotient (q_x)
  );

  kmc_div #(.DIVIDEND_W(SW), .DIVISOR_W(NW)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag_y),
    .divisor  (cnt[clu]),
    .done     (done_y),
    .quotient (q_y)
  );

  // centroids, accumulators and iteration flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cen_x[i] <= '0;
        cen_y[i] <= '0;
      end
      changed <= 1'b0;
      moved   <= 1'b0;
    end else begin
      if (cmd.seed_wr) begin
        cen_x[clu] <= rd_x;
        cen_y[clu] <= rd_y;
      end
      if (cmd.acc_clr) begin
        for (int i = 0; i < MAX_CLUSTERS; i++) begin
          sum_x[i] <= '0;
          sum_y[i] <= '0;
          cnt[i]   <= '0;
        end
        changed <= 1'b0;
        moved   <= 1'b0;
      end
      if (cmd.acc_wb) begin
        sum_x[best_c] <= sum_x[best_c] + SW'(rd_x);
        sum_y[best_c] <= sum_y[best_c] + SW'(rd_y);
        cnt[best_c]   <= cnt[best_c] + NW'(1);
        if (rd_lbl != {1'b1, best_c}) changed <= 1'b1;
      end
      if (cmd.cen_wb) begin
        cen_x[clu] <= new_x;
        cen_y[clu] <= new_y;
        // |new| is at most 2^15, far under 1e6, so any change is a move
        if (new_x != cen_x[clu] || new_y != cen_y[clu]) moved <= 1'b1;
      end
    end
  end

  assign st.cnt_zero = (cnt[clu] == '0);
  assign st.div_done = done_x & done_y;
  assign st.changed  = changed;
  assign st.moved    = moved;
  assign st.out_free = !rsp.valid || rsp.ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (cmd.out_load) begin
      rsp.kind            <= cmd.out_kind;
      rsp.iterations_used <= iter_count;
      rsp.last            <= cmd.out_last;
      if (cmd.out_kind == KIND_LABEL) begin
        rsp.cluster_id  <= rd_lbl[CW] ? CLU_W'(rd_lbl[CW-1:0]) : '0;
        rsp.label_valid <= rd_lbl[CW];
        rsp.centroid_x  <= '0;
        rsp.centroid_y  <= '0;
        rsp.converged   <= 1'b0;
      end else begin
        rsp.cluster_id  <= CLU_W'(clu);
        rsp.label_valid <= 1'b0;
        rsp.centroid_x  <= cen_x[clu];
        rsp.centroid_y  <= cen_y[clu];
        rsp.converged   <= conv;
      end
    end
  end

endmodule

[src/kmeans_2d_clustering.sv]
// ----------------------------------------------------------------------------
// kmeans_2d_clustering
// Lloyd k-means over 2-D Q8.8 points with sequencer and datapath.
//
//   channel  dir  handshake        payload
//   req      in   valid/ready      action, point_index, coord_x/y, seed_cluster
//   rsp      out  valid/ready      kind, cluster_id, label_valid, centroid_x/y,
//                                  iterations_used, converged, last
//   cfg      in   cfg_we           cfg_index, cfg_data
//
// Load writes the point directly; seed and query first read the point (query then
// waits for a free result slot). Start: each iteration runs a distance pass of
// every point against the k centroids, then the serial mean dividers, SW = 16 +
// log2(MAX_POINTS) bits wide, per non-empty cluster; then k report items, one per cycle when taken.
// After reset a clearing pass over all MAX_POINTS entries empties the label store;
// req.ready is low meanwhile. A stalled rsp holds the sequencer.
// ----------------------------------------------------------------------------
module kmeans_2d_clustering import kmc_pkg::*; #(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  kmc_in_if.sink              req,
  kmc_out_if.source           rsp,
  input  logic                cfg_we,
  input  logic [REGIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

  cmd_t              cmd;
  status_t           st;
  logic [PW-1:0]     addr;
  logic [CW-1:0]     clu;
  logic [ITER_W-1:0] iter_count;
  logic              conv;

  kmc_ctrl #(.MAX_POINTS(MAX_POINTS), .MAX_CLUSTERS(MAX_CLUSTERS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .action       (req.action),
    .point_index  (req.point_index),
    .seed_cluster (req.seed_cluster),
    .st           (st),
    .cmd          (cmd),
    .addr         (addr),
    .clu          (clu),
    .iter_count   (iter_count),
    .conv         (conv)
  );

  kmc_dp #(.MAX_POINTS(MAX_POINTS), .MAX_CLUSTERS(MAX_CLUSTERS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .addr       (addr),
    .clu        (clu),
    .coord_x    (req.coord_x),
    .coord_y    (req.coord_y),
    .iter_count (iter_count),
    .conv       (conv),
    .st         (st),
    .rsp        (rsp)
  );

endmodule
